// File: rtl/glpf_pkg.sv
// Shared types and constants for the grid local peak finder.
// No dependencies; compile first.
package glpf_pkg;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 11;
    localparam int PEAK_COORD_BITS = 10;
    localparam int DIM_RESET       = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic [PEAK_COORD_BITS-1:0] peak_row;
        logic [PEAK_COORD_BITS-1:0] peak_col;
    } peak_t;

    // line window control: load new read data, write the current column
    typedef struct packed {
        logic load;
        logic write;
    } win_ctl_t;

endpackage

// File: rtl/glpf_pixel_if.sv
// Input stream interface: valid/ready with mode and pixel_value payload.
// Depends on nothing.
interface glpf_pixel_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] pixel_value;

    modport source (output valid, mode, pixel_value, input ready);
    modport sink   (input valid, mode, pixel_value, output ready);
endinterface

// File: rtl/glpf_peak_if.sv
// Result stream interface: valid/ready with peak_row and peak_col payload.
// Depends on glpf_pkg.
interface glpf_peak_if ();
    logic                                valid;
    logic                                ready;
    logic [glpf_pkg::PEAK_COORD_BITS-1:0] peak_row;
    logic [glpf_pkg::PEAK_COORD_BITS-1:0] peak_col;

    modport source (output valid, peak_row, peak_col, input ready);
    modport sink   (input valid, peak_row, peak_col, output ready);
endinterface

// File: rtl/glpf_line_window.sv
// Two-line sample memory (latest row and row before, per column) with a
// registered read window of the current and next column. Depends on glpf_pkg.
module glpf_line_window #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  glpf_pkg::win_ctl_t                   ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr0,
    input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr1,
    input  logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]        wr_above,
    input  logic signed [SAMPLE_BITS-1:0]        wr_two,
    output logic signed [SAMPLE_BITS-1:0]        cur_above,
    output logic signed [SAMPLE_BITS-1:0]        cur_two,
    output logic signed [SAMPLE_BITS-1:0]        nxt_above
);
    import glpf_pkg::*;

    logic [2*SAMPLE_BITS-1:0] mem [MAX_WIDTH];
    logic [2*SAMPLE_BITS-1:0] wr_data;
    logic [2*SAMPLE_BITS-1:0] rd0_reg;
    logic [SAMPLE_BITS-1:0]   rd1_reg;

    assign wr_data = {wr_above, wr_two};

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-through forwarding for narrow frames
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            if (ctl.write && rd_addr0 == wr_addr)
            begin
                rd0_reg <= wr_data;
            end
            else
            begin
                rd0_reg <= mem[rd_addr0];
            end
            if (ctl.write && rd_addr1 == wr_addr)
            begin
                rd1_reg <= wr_above;
            end
            else
            begin
                rd1_reg <= mem[rd_addr1][2*SAMPLE_BITS-1:SAMPLE_BITS];
            end
        end
    end

    assign cur_above = rd0_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign cur_two   = rd0_reg[SAMPLE_BITS-1:0];
    assign nxt_above = rd1_reg;

endmodule

// File: rtl/glpf_out_buffer.sv
// Result register with one skid entry feeding the peak output stream.
// Depends on glpf_pkg and glpf_peak_if.
module glpf_out_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  glpf_pkg::peak_t   push_data,
    output logic              skid_full,
    glpf_peak_if.source       peaks
);
    import glpf_pkg::*;

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    peak_t main_reg, main_next;
    peak_t skid_reg, skid_next;
    logic  pop;

    assign pop = main_valid_reg && peaks.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign skid_full      = skid_valid_reg;
    assign peaks.valid    = main_valid_reg;
    assign peaks.peak_row = main_reg.peak_row;
    assign peaks.peak_col = main_reg.peak_col;

endmodule

// File: rtl/grid_local_peak_finder.sv
// Grid local peak finder: takes one raster item per clock while the output
// skid entry is free, and reports every element that is >= its existing up,
// down, left and right neighbours, in raster order. A pixel item decides the
// element one row above it; after the frame, frame_width flush items decide
// the last row. Results leave through a result register and a skid entry.
// The line memory is read one item ahead, so after reset and after every
// configuration write the block loads its window before it takes the first
// item; from then on it sustains one item per clock unless the skid is full.
// Depends on glpf_pkg, glpf_pixel_if, glpf_peak_if, glpf_line_window,
// glpf_out_buffer.
module grid_local_peak_finder #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [glpf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [glpf_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
    glpf_pixel_if.sink                            pixels,
    glpf_peak_if.source                           peaks
);
    import glpf_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int HGT_BITS = $clog2(MAX_HEIGHT + 1);
    localparam logic [WID_BITS-1:0] WIDTH_RESET =
        WID_BITS'((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET);
    localparam logic [HGT_BITS-1:0] HEIGHT_RESET =
        HGT_BITS'((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET);

    logic [WID_BITS-1:0] width_reg;
    logic [HGT_BITS-1:0] height_reg;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic                flushing_reg, flushing_next;
    logic                win_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;

    logic [WID_BITS-1:0] cfg_width;
    logic [HGT_BITS-1:0] cfg_height;
    logic                cfg_hit;

    logic                is_flush, take, advance, hit, up_exists, fail, skid_full;
    logic [WID_BITS-1:0] col_inc, next_inc;
    logic [HGT_BITS-1:0] row_inc;
    logic [ROW_BITS-1:0] row_dec;
    logic [COL_BITS-1:0] rd_addr1;
    logic signed [SAMPLE_BITS-1:0] px, cur_above, cur_two, nxt_above, wr_above;
    win_ctl_t            win_ctl;
    peak_t               peak;

    // register writes, clamped to the legal range
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cfg_width  = WID_BITS'(1);
            cfg_height = HGT_BITS'(1);
        end
        else
        begin
            if (32'(cfg_wr_data) > MAX_WIDTH)
            begin
                cfg_width = WID_BITS'(MAX_WIDTH);
            end
            else
            begin
                cfg_width = WID_BITS'(cfg_wr_data);
            end
            if (32'(cfg_wr_data) > MAX_HEIGHT)
            begin
                cfg_height = HGT_BITS'(MAX_HEIGHT);
            end
            else
            begin
                cfg_height = HGT_BITS'(cfg_wr_data);
            end
        end
        cfg_hit = cfg_wr_en &&
                  (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    end

    assign px       = pixels.pixel_value;
    assign is_flush = (pixels.mode == MODE_FLUSH);
    assign take     = pixels.valid && pixels.ready;
    assign advance  = take && (is_flush ? flushing_reg : !flushing_reg);

    // peak decision for the element held in the current window column
    always_comb
    begin
        col_inc   = WID_BITS'(col_reg) + WID_BITS'(1);
        up_exists = is_flush ? (height_reg > HGT_BITS'(1)) : (row_reg > ROW_BITS'(1));
        fail      = (up_exists && cur_above < cur_two) ||
                    (col_reg != '0 && cur_above < left_reg) ||
                    (col_inc < width_reg && cur_above < nxt_above) ||
                    (!is_flush && cur_above < px);
        hit       = advance && !fail && (is_flush || row_reg != '0);
        row_dec   = is_flush ? ROW_BITS'(height_reg - HGT_BITS'(1))
                             : (row_reg - ROW_BITS'(1));
        peak.peak_row = PEAK_COORD_BITS'(row_dec);
        peak.peak_col = PEAK_COORD_BITS'(col_reg);
        wr_above  = is_flush ? cur_above : px;
    end

    // position update
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        flushing_next = flushing_reg;
        row_inc       = HGT_BITS'(row_reg) + HGT_BITS'(1);
        if (advance)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                if (is_flush)
                begin
                    flushing_next = 1'b0;
                end
                else if (row_inc >= height_reg)
                begin
                    row_next      = '0;
                    flushing_next = 1'b1;
                end
                else
                begin
                    row_next = ROW_BITS'(row_inc);
                end
            end
            else
            begin
                col_next = COL_BITS'(col_inc);
            end
        end
        next_inc = WID_BITS'(col_next) + WID_BITS'(1);
        rd_addr1 = (next_inc < width_reg) ? COL_BITS'(next_inc) : col_next;
        win_ctl.load  = !win_valid_reg || advance;
        win_ctl.write = advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            flushing_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_width;
            end
            else
            begin
                height_reg <= cfg_height;
            end
            col_reg       <= '0;
            row_reg       <= '0;
            flushing_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            flushing_reg  <= flushing_next;
            win_valid_reg <= 1'b1;
        end
    end

    // left neighbour is the previous centre of the same pass
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_reg <= cur_above;
        end
    end

    assign pixels.ready = win_valid_reg && !skid_full;

    glpf_line_window #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk       (clk),
        .ctl       (win_ctl),
        .rd_addr0  (col_next),
        .rd_addr1  (rd_addr1),
        .wr_addr   (col_reg),
        .wr_above  (wr_above),
        .wr_two    (cur_above),
        .cur_above (cur_above),
        .cur_two   (cur_two),
        .nxt_above (nxt_above)
    );

    glpf_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hit),
        .push_data (peak),
        .skid_full (skid_full),
        .peaks     (peaks)
    );

endmodule
